@@ rtl/tle_pkg.sv @@
package tle_pkg;

    // line store geometry
    localparam int LINE_LEN = 32;
    localparam int ADDR_W   = $clog2(LINE_LEN);
    localparam int CNT_W    = $clog2(LINE_LEN + 1);

    // key codes
    localparam logic [7:0] KEY_NUL     = 8'h00;
    localparam logic [7:0] KEY_EOT     = 8'h04;
    localparam logic [7:0] KEY_BS      = 8'h08;
    localparam logic [7:0] KEY_ESC     = 8'h1B;
    localparam logic [7:0] KEY_BRACKET = 8'h5B;
    localparam logic [7:0] KEY_RIGHT   = 8'h43;
    localparam logic [7:0] KEY_LEFT    = 8'h44;
    localparam logic [7:0] KEY_ERASE   = 8'h4B;
    localparam logic [7:0] KEY_DEL     = 8'h7F;
    localparam logic [7:0] DIGIT_LO    = 8'h30;
    localparam logic [7:0] DIGIT_HI    = 8'h39;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_DELIM0 = 3'd0;
    localparam logic [2:0] REG_DELIM1 = 3'd1;
    localparam logic [2:0] REG_DELIM2 = 3'd2;
    localparam logic [2:0] REG_DELIM3 = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    typedef enum logic [2:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_ABORT,
        OP_ERASE,
        OP_INSERT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
        logic       delim;
    } cmd_t;

endpackage

@@ rtl/tle_ram.sv @@
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tle_front.sv @@
module tle_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output tle_pkg::cmd_t    q_cmd
);
    import tle_pkg::*;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_FIRST,
        ESC_SECOND,
        ESC_THIRD
    } esc_t;

    esc_t       esc_reg, esc_next;
    logic       bracket_reg, bracket_next;
    logic [7:0] delim_reg [4];
    logic [2:0] count_reg;
    logic       accept;
    logic       is_delim;
    logic [2:0] count_eff;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // delimiter match over the active registers
    always_comb
    begin
        count_eff = (count_reg > 3'd4) ? 3'd4 : count_reg;
        is_delim  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < count_eff && delim_reg[i] == rx_byte)
            begin
                is_delim = 1'b1;
            end
        end
    end

    // classify the byte
    always_comb
    begin
        esc_next     = esc_reg;
        bracket_next = bracket_reg;
        q_push       = 1'b0;
        q_cmd.op     = OP_INSERT;
        q_cmd.value  = rx_byte;
        q_cmd.delim  = is_delim;
        if (accept)
        begin
            unique case (esc_reg)
                ESC_FIRST:
                begin
                    bracket_next = (rx_byte == KEY_BRACKET);
                    esc_next     = ESC_SECOND;
                end
                ESC_SECOND:
                begin
                    if (bracket_reg && rx_byte >= DIGIT_LO && rx_byte <= DIGIT_HI)
                    begin
                        esc_next = ESC_THIRD;
                    end
                    else
                    begin
                        esc_next = ESC_IDLE;
                        if (bracket_reg && rx_byte == KEY_LEFT)
                        begin
                            q_push   = 1'b1;
                            q_cmd.op = OP_LEFT;
                        end
                        else if (bracket_reg && rx_byte == KEY_RIGHT)
                        begin
                            q_push   = 1'b1;
                            q_cmd.op = OP_RIGHT;
                        end
                    end
                end
                ESC_THIRD:
                begin
                    esc_next = ESC_IDLE;
                end
                default:
                begin
                    if (rx_byte == KEY_ESC)
                    begin
                        esc_next = ESC_FIRST;
                    end
                    else if (rx_byte == KEY_NUL || rx_byte == KEY_EOT)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_ABORT;
                    end
                    else if (rx_byte == KEY_BS || rx_byte == KEY_DEL)
                    begin
                        q_push   = 1'b1;
                        q_cmd.op = OP_ERASE;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
            endcase
        end
    end

    // escape state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= ESC_IDLE;
            bracket_reg  <= 1'b0;
            delim_reg[0] <= 8'd10;
            delim_reg[1] <= 8'd0;
            delim_reg[2] <= 8'd0;
            delim_reg[3] <= 8'd0;
            count_reg    <= 3'd1;
        end
        else
        begin
            esc_reg     <= esc_next;
            bracket_reg <= bracket_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DELIM0: delim_reg[0] <= cfg_data;
                    REG_DELIM1: delim_reg[1] <= cfg_data;
                    REG_DELIM2: delim_reg[2] <= cfg_data;
                    REG_DELIM3: delim_reg[3] <= cfg_data;
                    REG_COUNT:  count_reg    <= cfg_data[2:0];
                    default:    ;
                endcase
            end
        end
    end

endmodule

@@ rtl/tle_queue.sv @@
module tle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tle_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tle_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);
    import tle_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign pop_cmd = slot_reg[rd_reg];

    // two-entry command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_reg] <= push_cmd;
                wr_reg           <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/tle_back.sv @@
module tle_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  tle_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    kind,
    output logic [7:0]    data,
    output logic          last
);
    import tle_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEQ,
        ST_ABORT,
        ST_ESH_RD,
        ST_ESH_WR,
        ST_ECHO,
        ST_ISH_RD,
        ST_ISH_WR,
        ST_PLACE,
        ST_DUMP_RD,
        ST_DUMP_WR
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  cur_reg, len_reg, idx_reg;
    logic [2:0]        seq_reg, seq_max_reg;
    logic              erase_reg;
    logic [7:0]        seq_last_reg;
    logic              valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic              can_emit;
    logic [7:0]        seq_byte;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [CNT_W-1:0]  idx_inc, idx_dec;

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign can_emit  = !valid_reg || !out_stall;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);

    // bytes of ESC [ x ESC [ K
    always_comb
    begin
        case (seq_reg)
            3'd0, 3'd3: seq_byte = KEY_ESC;
            3'd1, 3'd4: seq_byte = KEY_BRACKET;
            3'd2:       seq_byte = seq_last_reg;
            default:    seq_byte = KEY_ERASE;
        endcase
    end

    // line store access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_ESH_RD, ST_ESH_WR: ram_raddr = idx_inc[ADDR_W-1:0];
            ST_ISH_RD, ST_ISH_WR: ram_raddr = idx_dec[ADDR_W-1:0];
            default:              ram_raddr = idx_reg[ADDR_W-1:0];
        endcase
        if (state_reg == ST_ESH_WR && can_emit)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_ISH_WR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_PLACE)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_reg[ADDR_W-1:0];
            ram_wdata = cmd_reg.value;
        end
    end

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            len_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_cmd;
                        seq_reg <= 3'd0;
                        unique case (q_cmd.op)
                            OP_LEFT:
                            begin
                                if (cur_reg != '0)
                                begin
                                    cur_reg      <= cur_reg - CNT_W'(1);
                                    seq_max_reg  <= 3'd2;
                                    seq_last_reg <= KEY_LEFT;
                                    erase_reg    <= 1'b0;
                                    state_reg    <= ST_SEQ;
                                end
                            end
                            OP_RIGHT:
                            begin
                                if (cur_reg < len_reg)
                                begin
                                    cur_reg      <= cur_reg + CNT_W'(1);
                                    seq_max_reg  <= 3'd2;
                                    seq_last_reg <= KEY_RIGHT;
                                    erase_reg    <= 1'b0;
                                    state_reg    <= ST_SEQ;
                                end
                            end
                            OP_ABORT:
                            begin
                                cur_reg   <= '0;
                                len_reg   <= '0;
                                state_reg <= ST_ABORT;
                            end
                            OP_ERASE:
                            begin
                                if (cur_reg != '0)
                                begin
                                    cur_reg      <= cur_reg - CNT_W'(1);
                                    len_reg      <= len_reg - CNT_W'(1);
                                    idx_reg      <= cur_reg - CNT_W'(1);
                                    seq_max_reg  <= 3'd5;
                                    seq_last_reg <= KEY_LEFT;
                                    erase_reg    <= 1'b1;
                                    state_reg    <= ST_SEQ;
                                end
                            end
                            default:
                            begin
                                if (len_reg < CNT_W'(LINE_LEN) || q_cmd.delim)
                                begin
                                    state_reg <= ST_ECHO;
                                end
                            end
                        endcase
                    end
                end
                ST_SEQ:
                begin
                    if (can_emit)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ECHO;
                        data_reg  <= seq_byte;
                        last_reg  <= (seq_reg == seq_max_reg)
                                     && (!erase_reg || cur_reg == len_reg);
                        seq_reg   <= seq_reg + 3'd1;
                        if (seq_reg == seq_max_reg)
                        begin
                            state_reg <= (erase_reg && cur_reg != len_reg)
                                         ? ST_ESH_RD : ST_IDLE;
                        end
                    end
                end
                ST_ABORT:
                begin
                    if (can_emit)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ABORT;
                        data_reg  <= 8'd0;
                        last_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ESH_RD:
                begin
                    state_reg <= ST_ESH_WR;
                end
                ST_ESH_WR:
                begin
                    // pull the tail left one place and redraw it
                    if (can_emit)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ECHO;
                        data_reg  <= ram_rdata;
                        last_reg  <= (idx_inc == len_reg);
                        idx_reg   <= idx_inc;
                        state_reg <= (idx_inc == len_reg) ? ST_IDLE : ST_ESH_RD;
                    end
                end
                ST_ECHO:
                begin
                    if (can_emit)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ECHO;
                        data_reg  <= cmd_reg.value;
                        last_reg  <= !cmd_reg.delim;
                        if (len_reg < CNT_W'(LINE_LEN))
                        begin
                            idx_reg   <= len_reg;
                            state_reg <= (len_reg > cur_reg) ? ST_ISH_RD : ST_PLACE;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_DUMP_RD;
                        end
                    end
                end
                ST_ISH_RD:
                begin
                    state_reg <= ST_ISH_WR;
                end
                ST_ISH_WR:
                begin
                    // open a gap at the cursor
                    idx_reg   <= idx_dec;
                    state_reg <= (idx_dec == cur_reg) ? ST_PLACE : ST_ISH_RD;
                end
                ST_PLACE:
                begin
                    len_reg <= len_reg + CNT_W'(1);
                    cur_reg <= cur_reg + CNT_W'(1);
                    idx_reg <= '0;
                    state_reg <= cmd_reg.delim ? ST_DUMP_RD : ST_IDLE;
                end
                ST_DUMP_RD:
                begin
                    state_reg <= ST_DUMP_WR;
                end
                ST_DUMP_WR:
                begin
                    if (can_emit)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_LINE;
                        data_reg  <= ram_rdata;
                        last_reg  <= (idx_inc == len_reg);
                        idx_reg   <= idx_inc;
                        if (idx_inc == len_reg)
                        begin
                            cur_reg   <= '0;
                            len_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_DUMP_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/terminal_line_editor.sv @@
// Terminal line editor.
// Input channel: in_valid / in_stall with rx_byte, one keyboard byte per
// transaction. Output channel: out_valid / out_stall with kind, data and
// last; last marks the final result of one input byte, and a byte with no
// result gives no transaction at all.
// Configuration: cfg_we, cfg_index, cfg_data write the four delimiter
// bytes (index 0..3) and the delimiter count (index 4).
// The front end decodes escape sequences and delimiters in the cycle a
// byte is taken and posts a command into a two-entry queue; the back end
// runs each command against a 32-byte line store with one write and one
// registered read port. With the back end idle, a taken byte's command is
// written into a queue slot, then taken into the back end's command
// register, and its first result is then set in the output register.
// Each stored byte that is shifted, redrawn or sent out as line data
// takes a read state and then a write state on the store port; an insert
// shifts the bytes from the cursor to the end, and a delimiter sends out
// the whole line. Reset clears cursor, length, escape state, the queue
// and the output valid flag, and loads delimiter 10 with a count of 1.
// When the receiver stalls, the output register holds, the back end
// waits, and once the queue is full in_stall rises.
module terminal_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tle_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, pop, full, empty;

    tle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    tle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (full),
        .empty    (empty)
    );

    tle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_cmd     (pop_cmd),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

@@ rtl/tle_checker.sv @@
module tle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data,
    input logic       last,
    input logic       cfg_we,
    input logic [2:0] cfg_index,
    input logic [7:0] cfg_data
);
    import tle_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(kind)
                                   && $stable(last))
        else $error("stalled result changed");

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
        else $error("stalled input changed");

    // no undefined kind
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("bad result kind");

    // abort is a single zero result
    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ABORT |-> last && data == 8'd0)
        else $error("malformed abort");

    // a line byte that is not the last is never followed directly by a result of another kind
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_LINE && !last
        ##1 out_valid |-> kind == KIND_LINE)
        else $error("line dump interrupted");

    // configuration writes only to known registers with defined data
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> cfg_index <= REG_COUNT && !$isunknown(cfg_data))
        else $error("bad configuration write");

endmodule

bind terminal_line_editor tle_checker u_chk (.*);

@@ bench/tb_top.sv @@
module tb_top;
    import tle_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } editor_out_t;

    // editor model state
    logic [7:0] mdl_store [LINE_LEN];
    int         mdl_cursor;
    int         mdl_length;
    int         mdl_esc_phase;
    logic [7:0] mdl_esc_first;
    logic [7:0] mdl_delim [4];
    int         mdl_delim_cnt;

    editor_out_t expected_q [$];
    int          mismatch_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    bit          timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    terminal_line_editor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted result helpers
    function automatic void push_result(logic [1:0] k, logic [7:0] d);
        editor_out_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void push_seq(logic [7:0] final_char);
        push_result(KIND_ECHO, KEY_ESC);
        push_result(KIND_ECHO, KEY_BRACKET);
        push_result(KIND_ECHO, final_char);
    endfunction

    function automatic bit is_delim(logic [7:0] b);
        int cnt;
        cnt = (mdl_delim_cnt > 4) ? 4 : mdl_delim_cnt;
        for (int i = 0; i < cnt; i++)
            if (mdl_delim[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    // work out the results of one keyboard byte
    function automatic void predict_keystroke(logic [7:0] b);
        int  first_idx;
        bit  dl;
        first_idx = expected_q.size();
        case (mdl_esc_phase)
            1:
            begin
                mdl_esc_first = b;
                mdl_esc_phase = 2;
            end
            2:
            begin
                if (mdl_esc_first == KEY_BRACKET && b >= DIGIT_LO && b <= DIGIT_HI)
                    mdl_esc_phase = 3;
                else
                begin
                    mdl_esc_phase = 0;
                    if (mdl_esc_first == KEY_BRACKET)
                    begin
                        if (b == KEY_LEFT && mdl_cursor > 0)
                        begin
                            mdl_cursor--;
                            push_seq(KEY_LEFT);
                        end
                        else if (b == KEY_RIGHT && mdl_cursor < mdl_length)
                        begin
                            mdl_cursor++;
                            push_seq(KEY_RIGHT);
                        end
                    end
                end
            end
            3:
                mdl_esc_phase = 0;
            default:
            begin
                if (b == KEY_ESC)
                    mdl_esc_phase = 1;
                else if (b == KEY_NUL || b == KEY_EOT)
                begin
                    push_result(KIND_ABORT, 8'h00);
                    mdl_length = 0;
                    mdl_cursor = 0;
                end
                else if (b == KEY_BS || b == KEY_DEL)
                begin
                    if (mdl_cursor > 0)
                    begin
                        for (int i = mdl_cursor - 1; i + 1 < mdl_length; i++)
                            mdl_store[i] = mdl_store[i + 1];
                        mdl_length--;
                        mdl_cursor--;
                        push_seq(KEY_LEFT);
                        push_seq(KEY_ERASE);
                        for (int i = mdl_cursor; i < mdl_length; i++)
                            push_result(KIND_ECHO, mdl_store[i]);
                    end
                end
                else
                begin
                    dl = is_delim(b);
                    if (mdl_length < LINE_LEN || dl)
                    begin
                        push_result(KIND_ECHO, b);
                        if (mdl_length < LINE_LEN)
                        begin
                            for (int i = mdl_length; i > mdl_cursor; i--)
                                mdl_store[i] = mdl_store[i - 1];
                            mdl_store[mdl_cursor] = b;
                            mdl_length++;
                            mdl_cursor++;
                        end
                        if (dl)
                        begin
                            for (int i = 0; i < mdl_length; i++)
                                push_result(KIND_LINE, mdl_store[i]);
                            mdl_length = 0;
                            mdl_cursor = 0;
                        end
                    end
                end
            end
        endcase
        if (expected_q.size() > first_idx)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    // send one keyboard byte as a transaction
    task automatic send_key(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_keystroke(b);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_key(s[i]);
    endtask

    // wait until all results have come, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DELIM0: mdl_delim[0] = val;
            REG_DELIM1: mdl_delim[1] = val;
            REG_DELIM2: mdl_delim[2] = val;
            REG_DELIM3: mdl_delim[3] = val;
            REG_COUNT:  mdl_delim_cnt = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_delims(logic [7:0] d0, logic [7:0] d1, logic [7:0] d2,
                              logic [7:0] d3, logic [2:0] cnt);
        drain();
        write_reg(REG_DELIM0, d0);
        write_reg(REG_DELIM1, d1);
        write_reg(REG_DELIM2, d2);
        write_reg(REG_DELIM3, d3);
        write_reg(REG_COUNT, cnt);
    endtask

    // random key drawn from editing-heavy mix
    function automatic logic [7:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return 8'($urandom_range(32, 126));
        else if (sel < 55)
            return KEY_ESC;
        else if (sel < 60)
            return KEY_BRACKET;
        else if (sel < 66)
            return ($urandom_range(1)) ? KEY_LEFT : KEY_RIGHT;
        else if (sel < 74)
            return ($urandom_range(1)) ? KEY_BS : KEY_DEL;
        else if (sel < 80)
            return mdl_delim[$urandom_range(3)];
        else if (sel < 83)
            return ($urandom_range(1)) ? KEY_NUL : KEY_EOT;
        else if (sel < 88)
            return 8'($urandom_range(48, 57));
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic send_random(int count);
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(9);
            if (sel < 3)
            begin
                send_key(KEY_ESC);
                send_key(KEY_BRACKET);
                send_key(($urandom_range(1)) ? KEY_LEFT : KEY_RIGHT);
            end
            else
                send_key(pick_key());
        end
    endtask

    // directed tests
    task automatic test_basic_line();
        send_string("ab");
        send_key(8'h0A);
        send_key(8'h80);
        send_key(8'hFF);
        send_key(8'h01);
        send_key(8'h0A);
    endtask

    task automatic test_cursor_moves();
        send_string("\033[D");
        send_string("xyz");
        send_string("\033[D\033[D");
        send_key(8'h7F);
        send_string("\033[C\033[C\033[C");
        send_key(KEY_BS);
        send_string("\033[D");
        send_key(KEY_BS);
        send_key(KEY_BS);
        send_string("\033[A\033[B\033[5~\033[6~\033x\0339q");
        send_key(KEY_ESC);
        send_key(KEY_NUL);
        send_key(KEY_EOT);
        send_key(KEY_NUL);
        send_key(KEY_EOT);
    endtask

    task automatic test_store_full();
        for (int i = 0; i < LINE_LEN + 2; i++)
            send_key(8'($urandom_range(32, 126)));
        send_string("\033[D");
        send_key(8'h0A);
    endtask

    task automatic test_random_phase(int count);
        send_random(count);
        send_key(mdl_delim[0]);
    endtask

    // receiver holds off long while the sender keeps going
    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_key(8'($urandom_range(32, 126)));
        send_key(8'h0A);
    endtask

    // receiver stall process
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            editor_out_t want;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction kind=%0d data=%h last=%b",
                             kind, data, last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.kind !== kind || want.data !== data || want.last !== last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d data=%h last=%b, got %0d %h %b",
                                 want.kind, want.data, want.last, kind, data, last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DELIM0;
        cfg_data = 8'h00;
        mismatch_count = 0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 73;
        mdl_cursor = 0;
        mdl_length = 0;
        mdl_esc_phase = 0;
        mdl_esc_first = 8'h00;
        mdl_delim[0] = 8'd10;
        mdl_delim[1] = 8'd0;
        mdl_delim[2] = 8'd0;
        mdl_delim[3] = 8'd0;
        mdl_delim_cnt = 1;
        for (int i = 0; i < LINE_LEN; i++)
            mdl_store[i] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_line();
        test_cursor_moves();
        test_store_full();
        test_backpressure();

        set_delims(8'hFF, 8'h00, 8'h2E, 8'h21, 3'd4);
        test_random_phase(12);

        send_idle_pct = 73;
        recv_idle_pct = 25;
        set_delims(8'h0D, 8'h3B, 8'h80, 8'h7E, 3'd7);
        test_random_phase(12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_delims(8'h0A, 8'h20, 8'h00, 8'h00, 3'd0);
        send_string("no end");
        send_key(KEY_NUL);
        set_delims(8'h0A, 8'h41, 8'h00, 8'h00, 3'd2);
        test_random_phase(10);

        drain();
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/tle_front.sv
rtl/tle_queue.sv
rtl/tle_back.sv
rtl/terminal_line_editor.sv
rtl/tle_checker.sv
bench/tb_top.sv
